// ----- design/teq_pkg.sv -----
// Shared types and constants for the timed event queue.
package teq_pkg;

    // Queue depth and derived index / occupancy widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    // Request kinds
    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_REMOVE  = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    // Result status codes
    localparam logic [2:0] STS_FIRED    = 3'd0;
    localparam logic [2:0] STS_ADDED    = 3'd1;
    localparam logic [2:0] STS_PAST     = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_REMOVED  = 3'd4;
    localparam logic [2:0] STS_ADV_DONE = 3'd5;

    // Request payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_value;
        logic [15:0] event_id;
    } t_request;

    // Result payload
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] fired_id;
        logic [31:0] fired_time;
        logic [4:0]  count;
        logic        last;
    } t_result;

endpackage

// ----- design/timed_event_queue.sv -----
// Timed event queue: sorted event store in a small memory walked by one compare unit.
// Add past/full is answered from idle with no walk; add insert, remove and advance walk the store,
// fired results one per cycle.
// Throughput: one request at a time; busy stays high while the store is walked (one entry
// per cycle through the single memory read port and the shared time comparator).
// Results appear for one cycle on o_strobe; the receiver cannot stall.
// Synchronous active-low reset empties the queue and clears the current time; no clearing pass.
module timed_event_queue
    import teq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_req,
    output logic     busy,
    output logic     o_strobe,
    output t_result  o_result
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_REM   = 6'b000100,
        S_FIRE  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    // Event store
    logic [31:0] mem_time [CAPACITY];
    logic [15:0] mem_id   [CAPACITY];

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_ra, n_ra;
    logic               r_ra_on, n_ra_on;
    logic               r_dv, n_dv;
    logic [OCC_W-1:0]   r_ptr, n_ptr;
    logic [OCC_W-1:0]   r_fired, n_fired;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [31:0]        r_now, n_now;
    logic [31:0]        r_key, n_key;
    logic [15:0]        r_id, n_id;
    t_result            r_res, n_res;
    logic               r_strobe, n_strobe;
    logic [31:0]        r_rd_time;
    logic [15:0]        r_rd_id;

    logic               we;
    logic [IDX_W-1:0]   wa;
    logic [31:0]        wtime;
    logic [15:0]        wid;
    logic               cmp_le;
    logic               cmp_eq;
    logic [31:0]        now_sum;
    logic               asc_more;

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_time[wa] <= wtime;
            mem_id[wa]   <= wid;
        end
        r_rd_time <= mem_time[r_ra];
        r_rd_id   <= mem_id[r_ra];
    end

    // Shared time comparator and adder
    assign cmp_le   = r_rd_time <= r_key;
    assign cmp_eq   = r_rd_time == r_key;
    assign now_sum  = r_now + i_req.time_value;
    assign asc_more = (OCC_W'(r_ra) + OCC_W'(1)) < r_occ;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_ra     = r_ra;
        n_ra_on  = r_ra_on;
        n_dv     = r_ra_on;
        n_ptr    = r_ptr;
        n_fired  = r_fired;
        n_occ    = r_occ;
        n_now    = r_now;
        n_key    = r_key;
        n_id     = r_id;
        n_res    = r_res;
        n_strobe = 1'b0;
        we       = 1'b0;
        wa       = r_ptr[IDX_W-1:0];
        wtime    = r_rd_time;
        wid      = r_rd_id;

        case (r_state)
            S_IDLE: begin
                n_dv = 1'b0;
                if (start) begin
                    n_res.fired_id   = 16'd0;
                    n_res.fired_time = r_now;
                    n_res.count      = 5'd0;
                    n_res.last       = 1'b1;
                    case (i_req.kind)
                        KIND_ADD: begin
                            if (i_req.time_value < r_now) begin
                                n_res.status = STS_PAST;
                                n_strobe     = 1'b1;
                            end else if (r_occ == OCC_W'(CAPACITY)) begin
                                n_res.status = STS_FULL;
                                n_strobe     = 1'b1;
                            end else begin
                                n_key   = i_req.time_value;
                                n_id    = i_req.event_id;
                                n_ptr   = r_occ;
                                n_ra    = IDX_W'(r_occ - OCC_W'(1));
                                n_ra_on = r_occ != '0;
                                n_state = S_ADD;
                            end
                        end
                        KIND_REMOVE: begin
                            n_key   = i_req.time_value;
                            n_ptr   = '0;
                            n_ra    = '0;
                            n_ra_on = r_occ != '0;
                            n_state = S_REM;
                        end
                        KIND_ADVANCE: begin
                            n_now   = now_sum;
                            n_key   = now_sum;
                            n_fired = '0;
                            n_ra    = '0;
                            n_ra_on = r_occ != '0;
                            n_state = S_FIRE;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Insertion: walk down from the top, moving later entries up by one
            S_ADD: begin
                n_ra_on = r_ra_on && (r_ra != '0);
                n_ra    = r_ra - IDX_W'(1);
                if (r_dv && !cmp_le) begin
                    we    = 1'b1;
                    n_ptr = r_ptr - OCC_W'(1);
                end else if (r_dv || !r_ra_on) begin
                    we               = 1'b1;
                    wtime            = r_key;
                    wid              = r_id;
                    n_occ            = r_occ + OCC_W'(1);
                    n_res.status     = STS_ADDED;
                    n_res.fired_id   = 16'd0;
                    n_res.fired_time = r_now;
                    n_res.count      = 5'd0;
                    n_res.last       = 1'b1;
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            // Removal: compact the store, dropping matching due times
            S_REM: begin
                n_ra_on = r_ra_on && asc_more;
                n_ra    = r_ra + IDX_W'(1);
                if (r_dv) begin
                    if (!cmp_eq) begin
                        we    = 1'b1;
                        n_ptr = r_ptr + OCC_W'(1);
                    end
                end else if (!r_ra_on) begin
                    n_occ            = r_ptr;
                    n_res.status     = STS_REMOVED;
                    n_res.fired_id   = 16'd0;
                    n_res.fired_time = r_now;
                    n_res.count      = 5'(r_occ - r_ptr);
                    n_res.last       = 1'b1;
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            // Firing: emit the due prefix of the store
            S_FIRE: begin
                n_ra_on = r_ra_on && asc_more;
                n_ra    = r_ra + IDX_W'(1);
                if (r_dv && cmp_le) begin
                    n_res.status     = STS_FIRED;
                    n_res.fired_id   = r_rd_id;
                    n_res.fired_time = r_rd_time;
                    n_res.count      = 5'd0;
                    n_res.last       = 1'b0;
                    n_strobe         = 1'b1;
                    n_fired          = r_fired + OCC_W'(1);
                end else if (r_dv || !r_ra_on) begin
                    n_ra    = r_fired[IDX_W-1:0];
                    n_ra_on = r_fired < r_occ;
                    n_dv    = 1'b0;
                    n_ptr   = '0;
                    n_state = S_SHIFT;
                end
            end

            // Shift the remaining entries down to the front
            S_SHIFT: begin
                n_ra_on = r_ra_on && asc_more;
                n_ra    = r_ra + IDX_W'(1);
                if (r_dv) begin
                    we    = 1'b1;
                    n_ptr = r_ptr + OCC_W'(1);
                end else if (!r_ra_on) begin
                    n_occ            = r_ptr;
                    n_res.status     = STS_ADV_DONE;
                    n_res.fired_id   = 16'd0;
                    n_res.fired_time = r_now;
                    n_res.count      = 5'(r_fired);
                    n_res.last       = 1'b1;
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_dv    = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ra_on  <= 1'b0;
            r_dv     <= 1'b0;
            r_occ    <= '0;
            r_now    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ra_on  <= n_ra_on;
            r_dv     <= n_dv;
            r_occ    <= n_occ;
            r_now    <= n_now;
            r_strobe <= n_strobe;
        end
        r_ra    <= n_ra;
        r_ptr   <= n_ptr;
        r_fired <= n_fired;
        r_key   <= n_key;
        r_id    <= n_id;
        r_res   <= n_res;
    end

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

// ----- tb/timed_event_queue_check.sv -----
// Checker for the timed event queue: predicts results per request and compares them.
module timed_event_queue_check
    import teq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_request i_req,
    input  logic     i_strobe,
    input  t_result  i_result,
    output int       o_fail_count,
    output int       o_pending
);

    // Predicted scheduler state
    logic [31:0] sched_due [CAPACITY];
    logic [15:0] sched_id  [CAPACITY];
    int          sched_occ;
    logic [31:0] sched_now;

    // Results still owed by the block, oldest first
    t_result     owed_results [$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void owe_result(input logic [2:0] status, input logic [15:0] id,
                                       input logic [31:0] tm, input int cnt,
                                       input logic last);
        t_result r;
        r.status     = status;
        r.fired_id   = id;
        r.fired_time = tm;
        r.count      = 5'(cnt);
        r.last       = last;
        owed_results.insert(owed_results.size(), r);
    endfunction

    // Apply one accepted request to the predicted state
    function automatic void schedule_request(input t_request r);
        int          pos;
        int          keep;
        int          fired;
        logic [2:0]  st;
        case (r.kind)
            KIND_ADD: begin
                if (r.time_value < sched_now) begin
                    st = STS_PAST;
                end else if (sched_occ >= CAPACITY) begin
                    st = STS_FULL;
                end else begin
                    // insert after every event due at or before the new one
                    pos = 0;
                    while (pos < sched_occ && sched_due[pos] <= r.time_value) pos++;
                    for (int j = sched_occ; j > pos; j--) begin
                        sched_due[j] = sched_due[j - 1];
                        sched_id[j]  = sched_id[j - 1];
                    end
                    sched_due[pos] = r.time_value;
                    sched_id[pos]  = r.event_id;
                    sched_occ++;
                    st = STS_ADDED;
                end
                owe_result(st, '0, sched_now, 0, 1'b1);
            end
            KIND_REMOVE: begin
                // compact, dropping every event due exactly at time_value
                keep = 0;
                for (int j = 0; j < sched_occ; j++) begin
                    if (sched_due[j] != r.time_value) begin
                        sched_due[keep] = sched_due[j];
                        sched_id[keep]  = sched_id[j];
                        keep++;
                    end
                end
                owe_result(STS_REMOVED, '0, sched_now, sched_occ - keep, 1'b1);
                sched_occ = keep;
            end
            KIND_ADVANCE: begin
                sched_now = sched_now + r.time_value;
                fired = 0;
                while (fired < sched_occ && sched_due[fired] <= sched_now) begin
                    owe_result(STS_FIRED, sched_id[fired], sched_due[fired], 0, 1'b0);
                    fired++;
                end
                for (int j = fired; j < sched_occ; j++) begin
                    sched_due[j - fired] = sched_due[j];
                    sched_id[j - fired]  = sched_id[j];
                end
                sched_occ = sched_occ - fired;
                owe_result(STS_ADV_DONE, '0, sched_now, fired, 1'b1);
            end
            default: ;  // undefined kind: no effect, no result
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Match one result against the oldest owed one
    function automatic void check_result(input t_result got);
        t_result want;
        if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            fail_count++;
        end else begin
            want = owed_results.pop_front();
            compare_field("status",     32'(want.status),     32'(got.status));
            compare_field("fired_id",   32'(want.fired_id),   32'(got.fired_id));
            compare_field("fired_time", want.fired_time,      got.fired_time);
            compare_field("count",      32'(want.count),      32'(got.count));
            compare_field("last",       32'(want.last),       32'(got.last));
        end
    endfunction

    // Watch both channels at every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sched_occ = 0;
            sched_now = '0;
            owed_results.delete();
        end else begin
            if (i_start && !i_busy) schedule_request(i_req);
            if (i_strobe) check_result(i_result);
        end
        o_pending = owed_results.size();
    end

endmodule

// ----- tb/timed_event_queue_test.sv -----
// Top of the timed event queue testbench: clock, reset, request stimulus and verdict.
module timed_event_queue_test
    import teq_pkg::*;
();

    // Kind code that the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_request    i_req;
    logic        busy;
    logic        o_strobe;
    t_result     o_result;
    int          fail_count;
    int          pending;

    // Sender-side view of current time and recently scheduled due times
    logic [31:0] plan_now = '0;
    logic [31:0] recent_due [8];
    int          recent_n = 0;
    int          burst_left = 0;

    timed_event_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    timed_event_queue_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Issue one request after a random gap; called and returns at a falling edge
    task automatic send_request(input logic [1:0] kind, input logic [31:0] tv,
                                input logic [15:0] id);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 19);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{kind, tv, id};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (kind == KIND_ADVANCE) plan_now = plan_now + tv;
        if (kind == KIND_ADD && tv >= plan_now) begin
            recent_due[recent_n % 8] = tv;
            recent_n++;
        end
    endtask

    // Hold off until every owed result has come
    task automatic drain_queue();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // One random request, mostly near the current time so events keep firing
    task automatic random_request(output bit counted);
        int          pick;
        int          sub;
        logic [1:0]  kind;
        logic [31:0] tv;
        logic [15:0] id;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        id   = 16'($urandom);
        if (pick < 50) begin
            kind = KIND_ADD;
            if (sub <= 5)      tv = plan_now + $urandom_range(0, 40);
            else if (sub == 6) tv = $urandom;
            else if (sub == 7) tv = plan_now - $urandom_range(1, 20);
            else if (sub == 8) tv = recent_due[$urandom_range(0, 7)];
            else               tv = plan_now;
        end else if (pick < 65) begin
            kind = KIND_REMOVE;
            tv   = (sub < 8) ? recent_due[$urandom_range(0, 7)] : $urandom;
        end else if (pick < 95) begin
            kind = KIND_ADVANCE;
            if (sub <= 5)      tv = $urandom_range(0, 30);
            else if (sub == 6) tv = $urandom;
            else if (sub == 7) tv = ~plan_now;
            else if (sub == 8) tv = 32'hFFFF_FFFF - $urandom_range(0, 50);
            else               tv = '0;
        end else begin
            kind = KIND_UNUSED;
            tv   = $urandom;
        end
        send_request(kind, tv, id);
        counted = (kind != KIND_UNUSED);
    endtask

    initial begin
        int sent;
        bit counted;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        foreach (recent_due[k]) recent_due[k] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty advance, ties, front insert, idle remove, ignored kind
        send_request(KIND_ADVANCE, 32'd0, 16'h0000);
        send_request(KIND_ADD, 32'd5, 16'h0000);
        send_request(KIND_ADD, 32'd5, 16'hFFFF);
        send_request(KIND_ADD, 32'd3, 16'h0001);
        send_request(KIND_REMOVE, 32'd7, 16'hFFFF);
        send_request(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(KIND_ADVANCE, 32'd5, 16'h0000);
        // past rejection, latest due time, due exactly now, single remove
        send_request(KIND_ADD, 32'd4, 16'h1234);
        send_request(KIND_ADD, 32'hFFFF_FFFF, 16'hAAAA);
        send_request(KIND_ADD, 32'd5, 16'h5555);
        send_request(KIND_REMOVE, 32'd5, 16'h0000);
        // fill to capacity, then one more is rejected as full
        for (int k = 0; k < CAPACITY - 1; k++) begin
            send_request(KIND_ADD, plan_now + 32'(k % 4), 16'(k * 4099));
        end
        send_request(KIND_ADD, plan_now + 32'd2, 16'hBEEF);
        // fire the whole queue at the top of the time range, then wrap to zero
        send_request(KIND_ADVANCE, ~plan_now, 16'h0000);
        send_request(KIND_ADVANCE, 32'd1, 16'h0000);
        drain_queue();

        // Random requests, with periodic drains and gap-free bursts
        sent = 0;
        while (sent < 300) begin
            if (sent % 60 == 59) drain_queue();
            if (burst_left == 0 && $urandom_range(0, 29) == 0)
                burst_left = $urandom_range(10, 30);
            random_request(counted);
            if (counted) sent++;
        end

        drain_queue();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
